// ===== hw/rtl/bmp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_pkg
// Types and constants shared by the BLE-MIDI packet parser modules.
// ----------------------------------------------------------------------------
package bmp_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_STAMP1_OK  = 3'd1,
    PH_STAMP1_BAD = 3'd2,
    PH_MSG_START  = 3'd3,
    PH_AFTER_TS   = 3'd4,
    PH_DATA       = 3'd5,
    PH_DISCARD    = 3'd7
  } phase_e;

  // Result kinds
  localparam logic [2:0] KIND_ERROR = 3'd7;

  // Error codes
  localparam logic [2:0] ERR_SHORT     = 3'd0;
  localparam logic [2:0] ERR_HEADER    = 3'd1;
  localparam logic [2:0] ERR_NO_STATUS = 3'd2;
  localparam logic [2:0] ERR_SYSTEM    = 3'd3;
  localparam logic [2:0] ERR_TRUNC     = 3'd4;

  // Status command nibbles
  localparam logic [3:0] CMD_PROGRAM = 4'hC;
  localparam logic [3:0] CMD_CTOUCH  = 4'hD;
  localparam logic [3:0] CMD_BEND    = 4'hE;
  localparam logic [3:0] CMD_SYSTEM  = 4'hF;

  localparam int unsigned EnableW = 7;
  localparam int unsigned StampW  = 13;

  // One result item
  typedef struct packed {
    logic [2:0]        event_kind;
    logic [3:0]        channel;
    logic [6:0]        first_value;
    logic [6:0]        second_value;
    logic [13:0]       bend_value;
    logic [StampW-1:0] time_stamp;
    logic [2:0]        error_code;
  } res_t;

  localparam int unsigned ResW = $bits(res_t);

endpackage
`default_nettype wire

// ===== hw/rtl/ble_midi_packet_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ble_midi_packet_parser
// BLE-MIDI packet parser: packet bytes in, channel voice events or one
// error result per bad packet out.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tdata = packet_byte, tuser = first,
//                                        tlast = last byte of packet
// m_axis    out  tvalid/tready           tdata = result fields, tuser = kind
// cfg       in   cfg_valid_i/cfg_ready_o cfg_data_i = event_enable[6:0]
//
// One byte per cycle: the parser state machine in the front handles a byte
// in the cycle it is transferred. A result reaches m_axis through the queue
// write and then the output register. s_axis_tready drops only while the
// result queue is full, i.e. when m_axis is stalled; bytes that produce no
// result still wait on that. Reset is asynchronous, active low, and leaves
// the parser awaiting a packet header with all events enabled.
//
module ble_midi_packet_parser #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] packet_byte
  input  wire logic [0:0]  s_axis_tuser,  // [0] first_in_packet
  input  wire logic        s_axis_tlast,  // last_in_packet
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // [3:0] channel, [10:4] first_value,
                                          // [17:11] second_value,
                                          // [31:18] bend_value,
                                          // [44:32] time_stamp,
                                          // [47:45] error_code
  output logic [2:0]       m_axis_tuser,  // [2:0] event_kind
  // event enable register
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i
);
  import bmp_pkg::*;

  logic in_fire, push, full, head_vld, pop;
  res_t push_data, head_data;

  // register always writable; the user must write it only while idle, the block does not enforce it
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  bmp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_fire_i   (in_fire),
    .byte_i      (s_axis_tdata),
    .first_i     (s_axis_tuser[0]),
    .last_i      (s_axis_tlast),
    .push_o      (push),
    .push_data_o (push_data)
  );

  bmp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (full),
    .head_vld_o  (head_vld),
    .head_data_o (head_data)
  );

  bmp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_vld_i    (head_vld),
    .head_data_i   (head_data),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/bmp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_front
// Parser front end: takes one packet byte per transfer, runs the packet
// state machine and hands each produced result to the queue.
// ----------------------------------------------------------------------------
module bmp_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [6:0]             cfg_data_i,
  input  wire logic                   in_fire_i,
  input  wire logic [7:0]             byte_i,
  input  wire logic                   first_i,
  input  wire logic                   last_i,
  output logic                        push_o,
  output bmp_pkg::res_t               push_data_o
);
  import bmp_pkg::*;

  logic [EnableW-1:0] en_q;
  phase_e             phase_q, phase_d;
  logic [7:0]         rstat_q, rstat_d;
  logic [StampW-1:0]  stamp_q, stamp_d;
  logic [6:0]         held_q, held_d;
  logic               seen_q, seen_d;

  logic       take, seen_eff, err_vld, evt_vld, one_byte;
  logic [2:0] err_code;
  logic [3:0] cmd;
  logic [6:0] d, v1, v2;
  res_t       res;

  assign d   = byte_i[6:0];
  assign cmd = rstat_q[7:4];

  always_comb begin
    phase_d  = phase_q;
    rstat_d  = rstat_q;
    stamp_d  = stamp_q;
    held_d   = held_q;
    seen_d   = seen_q;
    take     = 1'b0;
    seen_eff = seen_q;
    err_vld  = 1'b0;
    err_code = ERR_SHORT;
    evt_vld  = 1'b0;
    one_byte = 1'b0;
    v1       = '0;
    v2       = '0;

    if (first_i || phase_q == PH_HEADER) begin
      rstat_d = '0;
      held_d  = '0;
      seen_d  = 1'b0;
      stamp_d = {byte_i[5:0], 7'd0};
      if (last_i) begin
        err_vld  = 1'b1;
        err_code = ERR_SHORT;
      end else begin
        phase_d = byte_i[7] ? PH_STAMP1_OK : PH_STAMP1_BAD;
      end
    end else begin
      unique case (phase_q)
        PH_STAMP1_OK, PH_STAMP1_BAD: begin
          if (last_i) begin
            err_vld  = 1'b1;
            err_code = ERR_SHORT;
          end else if (phase_q == PH_STAMP1_BAD || !byte_i[7]) begin
            err_vld  = 1'b1;
            err_code = ERR_HEADER;
          end else begin
            stamp_d = {stamp_q[12:7], d};
            phase_d = PH_AFTER_TS;
          end
        end
        PH_MSG_START: begin
          if (byte_i[7]) begin
            stamp_d = {stamp_q[12:7], d};
            if (last_i) begin
              err_vld  = 1'b1;
              err_code = ERR_TRUNC;
            end else begin
              phase_d = PH_AFTER_TS;
            end
          end else if (rstat_q == 8'd0) begin
            err_vld  = 1'b1;
            err_code = ERR_NO_STATUS;
          end else begin
            take     = 1'b1;
            seen_eff = 1'b0;
          end
        end
        PH_AFTER_TS: begin
          if (byte_i[7]) begin
            rstat_d = byte_i;
            seen_d  = 1'b0;
            if (byte_i[7:4] == CMD_SYSTEM) begin
              err_vld  = 1'b1;
              err_code = ERR_SYSTEM;
            end else if (last_i) begin
              err_vld  = 1'b1;
              err_code = ERR_TRUNC;
            end else begin
              phase_d = PH_DATA;
            end
          end else if (rstat_q == 8'd0) begin
            err_vld  = 1'b1;
            err_code = ERR_NO_STATUS;
          end else begin
            take     = 1'b1;
            seen_eff = 1'b0;
          end
        end
        PH_DATA: begin
          take = 1'b1;
        end
        default: begin
          if (last_i) phase_d = PH_HEADER;
        end
      endcase
    end

    // data byte inside a message
    if (take) begin
      one_byte = (cmd == CMD_PROGRAM) || (cmd == CMD_CTOUCH);
      if (!one_byte && !seen_eff) begin
        held_d  = d;
        seen_d  = 1'b1;
        phase_d = PH_DATA;
        if (last_i) begin
          err_vld  = 1'b1;
          err_code = ERR_TRUNC;
        end
      end else begin
        v1      = one_byte ? d : held_q;
        v2      = one_byte ? 7'd0 : d;
        seen_d  = 1'b0;
        phase_d = last_i ? PH_HEADER : PH_MSG_START;
        evt_vld = en_q[cmd[2:0]];
      end
    end

    if (err_vld) phase_d = last_i ? PH_HEADER : PH_DISCARD;
  end

  always_comb begin
    res = '0;
    res.time_stamp = stamp_d;
    if (err_vld) begin
      res.event_kind = KIND_ERROR;
      res.error_code = err_code;
    end else begin
      res.event_kind   = cmd[2:0];
      res.channel      = rstat_q[3:0];
      res.first_value  = v1;
      res.second_value = v2;
      res.bend_value   = (cmd == CMD_BEND) ? {v2, v1} : 14'd0;
    end
  end

  assign push_o      = in_fire_i && (err_vld || evt_vld);
  assign push_data_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= '1;
      phase_q <= PH_HEADER;
      rstat_q <= '0;
      stamp_q <= '0;
      held_q  <= '0;
      seen_q  <= 1'b0;
    end else begin
      if (cfg_we_i) en_q <= cfg_data_i;
      if (in_fire_i) begin
        phase_q <= phase_d;
        rstat_q <= rstat_d;
        stamp_q <= stamp_d;
        held_q  <= held_d;
        seen_q  <= seen_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bmp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_queue
// Short result queue between parser and output stage.
// ----------------------------------------------------------------------------
module bmp_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  bmp_pkg::res_t      push_data_i,
  input  wire logic          pop_i,
  output logic               full_o,
  output logic               head_vld_o,
  output bmp_pkg::res_t      head_data_o
);
  import bmp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o      = (cnt_q == Full);
  assign head_vld_o  = (cnt_q != '0);
  assign head_data_o = mem_q[rptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && head_vld_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      if (do_pop)  rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bmp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_back
// Output stage: holds one result and packs it onto the master stream.
// ----------------------------------------------------------------------------
module bmp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_vld_i,
  input  bmp_pkg::res_t      head_data_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [47:0]        m_axis_tdata,
  output logic [2:0]         m_axis_tuser
);
  import bmp_pkg::*;

  logic vld_q;
  res_t res_q;

  // load when empty or the held result is being taken
  assign pop_o = head_vld_i && (!vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!vld_q || m_axis_tready) begin
      vld_q <= head_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= head_data_i;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = res_q.event_kind;
  assign m_axis_tdata  = {res_q.error_code, res_q.time_stamp, res_q.bend_value,
                          res_q.second_value, res_q.first_value, res_q.channel};

endmodule
`default_nettype wire

// ===== dv/midi_event_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_event_checker
// Watches the byte, event and enable channels of the BLE-MIDI packet parser,
// predicts the event stream byte by byte and compares it in order.
// ----------------------------------------------------------------------------
module midi_event_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,
  input  logic        s_first_i,
  input  logic        s_last_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [47:0] m_data_i,
  input  logic [2:0]  m_kind_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [6:0]  cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  import bmp_pkg::*;

  // parser state as predicted
  phase_e      phase_q     = PH_HEADER;
  logic [7:0]  status_q    = '0;
  logic [12:0] stamp_q     = '0;
  logic [6:0]  held_q      = '0;
  bit          held_full_q = 1'b0;
  logic [6:0]  enable_q    = 7'h7F;

  res_t expected_events[$];
  int   mismatches = 0;

  function automatic bit error_event(input logic [2:0] code, input bit last,
                                     output res_t ev);
    ev = '0;
    ev.event_kind = KIND_ERROR;
    ev.time_stamp = stamp_q;
    ev.error_code = code;
    phase_q = last ? PH_HEADER : PH_DISCARD;
    return 1'b1;
  endfunction

  // data byte of a channel voice message under status_q
  function automatic bit voice_data(input logic [6:0] d, input bit last, output res_t ev);
    logic [3:0]  cmd;
    logic [2:0]  kind;
    bit          one_byte;
    logic [6:0]  v1;
    logic [6:0]  v2;
    logic [13:0] bend;
    cmd      = status_q[7:4];
    kind     = cmd[2:0];
    one_byte = (cmd == CMD_PROGRAM) || (cmd == CMD_CTOUCH);
    ev       = '0;
    if (!one_byte && !held_full_q) begin
      held_q      = d;
      held_full_q = 1'b1;
      phase_q     = PH_DATA;
      if (last) return error_event(ERR_TRUNC, 1'b1, ev);
      return 1'b0;
    end
    if (one_byte) begin
      v1 = d;
      v2 = '0;
    end else begin
      v1 = held_q;
      v2 = d;
    end
    bend        = (cmd == CMD_BEND) ? {v2, v1} : '0;
    held_full_q = 1'b0;
    phase_q     = last ? PH_HEADER : PH_MSG_START;
    if (!enable_q[kind]) return 1'b0;
    ev.event_kind   = kind;
    ev.channel      = status_q[3:0];
    ev.first_value  = v1;
    ev.second_value = v2;
    ev.bend_value   = bend;
    ev.time_stamp   = stamp_q;
    return 1'b1;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input bit first, input bit last,
                                    output res_t ev);
    ev = '0;
    if (first || phase_q == PH_HEADER) begin
      status_q    = '0;
      held_q      = '0;
      held_full_q = 1'b0;
      stamp_q     = {b[5:0], 7'd0};
      if (last) return error_event(ERR_SHORT, 1'b1, ev);
      phase_q = b[7] ? PH_STAMP1_OK : PH_STAMP1_BAD;
      return 1'b0;
    end
    case (phase_q)
      PH_STAMP1_OK, PH_STAMP1_BAD: begin
        // short packet wins over a bad header
        if (last) return error_event(ERR_SHORT, 1'b1, ev);
        if (phase_q == PH_STAMP1_BAD || !b[7]) return error_event(ERR_HEADER, 1'b0, ev);
        stamp_q[6:0] = b[6:0];
        phase_q      = PH_AFTER_TS;
        return 1'b0;
      end
      PH_MSG_START, PH_AFTER_TS: begin
        if (b[7]) begin
          if (phase_q == PH_MSG_START) begin
            stamp_q[6:0] = b[6:0];
            if (last) return error_event(ERR_TRUNC, 1'b1, ev);
            phase_q = PH_AFTER_TS;
            return 1'b0;
          end
          status_q    = b;
          held_full_q = 1'b0;
          if (b[7:4] == CMD_SYSTEM) return error_event(ERR_SYSTEM, last, ev);
          if (last) return error_event(ERR_TRUNC, 1'b1, ev);
          phase_q = PH_DATA;
          return 1'b0;
        end
        if (status_q == '0) return error_event(ERR_NO_STATUS, last, ev);
        held_full_q = 1'b0;
        return voice_data(b[6:0], last, ev);
      end
      PH_DATA: return voice_data(b[6:0], last, ev);
      default: begin
        if (last) phase_q = PH_HEADER;
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t got;
    res_t want;
    res_t ev;
    if (!rst_ni) begin
      phase_q     = PH_HEADER;
      status_q    = '0;
      stamp_q     = '0;
      held_q      = '0;
      held_full_q = 1'b0;
      enable_q    = 7'h7F;
    end else begin
      // compare before predicting, so a stray event never meets a fresh entry
      if (m_valid_i && m_ready_i) begin
        got.event_kind   = m_kind_i;
        got.channel      = m_data_i[3:0];
        got.first_value  = m_data_i[10:4];
        got.second_value = m_data_i[17:11];
        got.bend_value   = m_data_i[31:18];
        got.time_stamp   = m_data_i[44:32];
        got.error_code   = m_data_i[47:45];
        if (expected_events.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected event", $realtime);
            $display("  exp none");
            $display("  got kind %0d ch %0d v1 %0d v2 %0d bend %0d ts %0d err %0d",
                     got.event_kind, got.channel, got.first_value,
                     got.second_value, got.bend_value, got.time_stamp,
                     got.error_code);
          end
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          if (got.event_kind !== want.event_kind || got.channel !== want.channel ||
              got.first_value !== want.first_value ||
              got.second_value !== want.second_value ||
              got.bend_value !== want.bend_value || got.time_stamp !== want.time_stamp ||
              got.error_code !== want.error_code) begin
            if (mismatches < 10) begin
              $display("%0t: event mismatch", $realtime);
              $display("  exp kind %0d ch %0d v1 %0d v2 %0d bend %0d ts %0d err %0d",
                       want.event_kind, want.channel, want.first_value,
                       want.second_value, want.bend_value, want.time_stamp,
                       want.error_code);
              $display("  got kind %0d ch %0d v1 %0d v2 %0d bend %0d ts %0d err %0d",
                       got.event_kind, got.channel, got.first_value,
                       got.second_value, got.bend_value, got.time_stamp,
                       got.error_code);
            end
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) enable_q = cfg_data_i;
      if (s_valid_i && s_ready_i) begin
        if (parse_byte(s_data_i, s_first_i, s_last_i, ev)) expected_events.push_back(ev);
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_events.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds BLE-MIDI packets (clean, damaged and noise) into the packet parser
// under a range of event-enable settings, with random idles on both
// streams, a long event-side hold-off and a full drain mid-run.
// ----------------------------------------------------------------------------
module testbench;
  import bmp_pkg::*;

  localparam int unsigned ClkHalf    = 10;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;   // long event-side hold-off
  localparam int unsigned TailCycles = 8;     // settle time before cfg / verdict
  localparam int unsigned PhaseBytes = 150;

  localparam logic [7:0] HighBit      = 8'h80;
  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;  // lowest channel voice command
  localparam logic [6:0] EnableAll    = 7'h7F;
  localparam logic [6:0] EnableNone   = 7'h00;
  localparam logic [6:0] EnableOdd    = 7'h55;
  localparam logic [6:0] EnableEven   = 7'h2A;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;

  // byte stream
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] packet_byte
  logic [0:0]  s_axis_tuser  = '0;   // [0] first_in_packet
  logic        s_axis_tlast  = 1'b0;
  // event stream
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // [3:0] channel, [10:4] first_value,
                                     // [17:11] second_value, [31:18] bend_value,
                                     // [44:32] time_stamp, [47:45] error_code
  logic [2:0]  m_axis_tuser;         // [2:0] event_kind
  // enable register
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data  = '0;

  int          fail_count;
  int          events_pending;
  int          bytes_sent  = 0;
  int          cycle_count = 0;

  // traffic shaping
  bit          tx_quiet     = 1'b0;   // when set, sender never idles
  logic        rx_quiet     = 1'b0;   // when set, event side always ready
  logic        hold_off_req = 1'b0;   // one long event-side stall

  logic [7:0]  pkt_bytes[$];

  always #(ClkHalf) clk = ~clk;

  ble_midi_packet_parser u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  midi_event_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_first_i   (s_axis_tuser[0]),
    .s_last_i    (s_axis_tlast),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .m_kind_i    (m_axis_tuser),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (events_pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // event sink: ~30% random stalls, one long hold-off on request
  initial begin : event_sink
    bit held_once;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !held_once) begin
        held_once = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      m_axis_tready <= rx_quiet || ($urandom_range(99) >= 30);
    end
  end

  // one byte transfer; tvalid stays up afterwards until the next call decides
  task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
    if (!tx_quiet) begin
      while ($urandom_range(99) < 30) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet(input bit mark_header);
    foreach (pkt_bytes[i])
      send_byte(pkt_bytes[i], (i == 0) && mark_header, i == pkt_bytes.size() - 1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (events_pending != 0) @(posedge clk);
  endtask

  task automatic write_enable(input logic [6:0] value);
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // packet: header, timestamp, 1..4 channel voice messages, sometimes a truncating trailing timestamp
  task automatic build_packet();
    int unsigned n_msg;
    int unsigned n_data;
    logic [3:0]  cmd;
    logic [7:0]  data;
    bit          have_status;
    bit          fresh;
    pkt_bytes.delete();
    pkt_bytes.push_back(HighBit | 8'($urandom_range(63)));
    pkt_bytes.push_back(HighBit | 8'($urandom_range(127)));
    have_status = 1'b0;
    cmd         = CMD_NOTE_OFF;
    n_msg       = $urandom_range(4, 1);
    for (int m = 0; m < n_msg; m++) begin
      fresh = !have_status || ($urandom_range(2) == 0);
      // a new status after a message needs a timestamp in front of it
      if (m > 0 && (fresh || $urandom_range(99) < 30))
        pkt_bytes.push_back(HighBit | 8'($urandom_range(127)));
      if (fresh) begin
        cmd = CMD_NOTE_OFF + 4'($urandom_range(6));
        pkt_bytes.push_back({cmd, 4'($urandom_range(15))});
        have_status = 1'b1;
      end
      n_data = (cmd == CMD_PROGRAM || cmd == CMD_CTOUCH) ? 1 : 2;
      for (int k = 0; k < n_data; k++) begin
        data = 8'($urandom_range(127));
        // high bit is only data once inside the message
        if ((fresh || k > 0) && $urandom_range(7) == 0) data = data | HighBit;
        pkt_bytes.push_back(data);
      end
    end
    // trailing timestamp: truncated
    if ($urandom_range(9) == 0) pkt_bytes.push_back(HighBit | 8'($urandom_range(127)));
  endtask

  task automatic damage_packet();
    int unsigned keep;
    case ($urandom_range(5))
      0: begin
        keep = $urandom_range(pkt_bytes.size(), 1);
        while (pkt_bytes.size() > keep) pkt_bytes.delete(pkt_bytes.size() - 1);
      end
      1: pkt_bytes[0] = pkt_bytes[0] & ~HighBit;
      2: pkt_bytes[1] = pkt_bytes[1] & ~HighBit;
      3: pkt_bytes[2] = {CMD_SYSTEM, 4'($urandom_range(15))};
      4: pkt_bytes[2] = 8'($urandom_range(127));     // data with no status
      default: foreach (pkt_bytes[i]) pkt_bytes[i] = 8'($urandom);
    endcase
  endtask

  task automatic random_phase(input int n, input bit pause_midway);
    int start;
    int r;
    bit paused;
    start  = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - start < n) begin
      r = $urandom_range(99);
      build_packet();
      if (r < 20) damage_packet();
      if (r >= 92) begin
        // loose bytes: abandon mid-packet or stray header marks
        repeat ($urandom_range(4, 1))
          send_byte(8'($urandom), 1'($urandom_range(1)), $urandom_range(3) == 0);
        send_packet(1'b1);
      end else begin
        send_packet($urandom_range(9) != 0);
      end
      if (pause_midway && !paused && bytes_sent - start >= n / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_enable(EnableAll);

    // directed: short packets, bad header / timestamp, no status, system,
    // bend extremes with high-bit data, running status, truncated after ts
    pkt_bytes = '{8'h80};
    send_packet(1'b1);
    pkt_bytes = '{8'h3F, 8'h80};
    send_packet(1'b0);
    pkt_bytes = '{8'hBF, 8'h7F, 8'h90};
    send_packet(1'b1);
    pkt_bytes = '{8'h80, 8'h80, 8'h45};
    send_packet(1'b1);
    pkt_bytes = '{8'hBF, 8'hFF, {CMD_SYSTEM, 4'h0}};
    send_packet(1'b1);
    pkt_bytes = '{8'hBF, 8'hFF, {CMD_BEND, 4'h5}, 8'h7F, 8'hFF, 8'h00, 8'h00,
                  8'h85, {CMD_PROGRAM, 4'h3}, 8'h7F, 8'h80};
    send_packet(1'b1);

    write_enable(EnableNone);
    random_phase(PhaseBytes, 1'b0);

    write_enable(EnableAll);
    hold_off_req <= 1'b1;           // sink stalls while bytes keep coming
    random_phase(PhaseBytes, 1'b0);

    write_enable(EnableOdd);
    random_phase(PhaseBytes, 1'b1);

    write_enable(EnableEven);
    tx_quiet = 1'b1;
    rx_quiet <= 1'b1;
    random_phase(PhaseBytes, 1'b0);
    tx_quiet = 1'b0;
    rx_quiet <= 1'b0;

    write_enable(7'($urandom_range(127)));
    random_phase(PhaseBytes, 1'b0);

    write_enable(EnableAll);
    random_phase(PhaseBytes, 1'b0);

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && events_pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== ble_midi_packet_parser.f =====
hw/rtl/bmp_pkg.sv
hw/rtl/bmp_front.sv
hw/rtl/bmp_queue.sv
hw/rtl/bmp_back.sv
hw/rtl/ble_midi_packet_parser.sv
dv/midi_event_checker.sv
dv/testbench.sv
